@@ rtl/core/pwbc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwbc_pkg: shared types, constants and helpers of the line compositor
// Holds the line entry layout, the register file layout, register indexes,
// effect mode codes and the small color and window helper functions.
// ----------------------------------------------------------------------------
package pwbc_pkg;

  // Default line length in pixels
  localparam int LINE_WIDTH_DEF = 240;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_WINDOW_ENABLES    = 3'd0;
  localparam logic [2:0] REG_WIN0_BOUNDS       = 3'd1;
  localparam logic [2:0] REG_WIN1_BOUNDS       = 3'd2;
  localparam logic [2:0] REG_INSIDE_MASKS      = 3'd3;
  localparam logic [2:0] REG_OUTSIDE_MASKS     = 3'd4;
  localparam logic [2:0] REG_EFFECT_CONTROL    = 3'd5;
  localparam logic [2:0] REG_BLEND_COEFFS      = 3'd6;
  localparam logic [2:0] REG_BRIGHTNESS_FACTOR = 3'd7;

  // Effect mode codes
  localparam logic [1:0] MODE_ALPHA    = 2'd1;
  localparam logic [1:0] MODE_BRIGHTEN = 2'd2;
  localparam logic [1:0] MODE_DARKEN   = 2'd3;

  // Item kinds
  localparam logic FUNC_BACKDROP = 1'b0;

  // Reset and backdrop values
  localparam logic [15:0] OUTSIDE_MASKS_RST = 16'h003F;
  localparam logic [7:0]  MASK_ALL          = 8'h3F;
  localparam logic [2:0]  BACKDROP_PRIO     = 3'd4;
  localparam logic [5:0]  BACKDROP_LAYER    = 6'h20;
  localparam logic [4:0]  COEFF_MAX         = 5'd16;
  localparam logic [7:0]  CHAN_MAX          = 8'd255;

  // One entry of the line buffer
  typedef struct packed {
    logic [23:0] color;
    logic [2:0]  prio;
    logic [5:0]  layer;
  } entry_t;

  // One input item
  typedef struct packed {
    logic        func;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [14:0] color;
    logic [1:0]  prio;
    logic [4:0]  layer;
    logic        semi;
    logic        objwin;
  } pix_t;

  // Register file
  typedef struct packed {
    logic [2:0]  window_enables;
    logic [31:0] win0_bounds;
    logic [31:0] win1_bounds;
    logic [15:0] inside_masks;
    logic [15:0] outside_masks;
    logic [13:0] effect_control;
    logic [12:0] blend_coeffs;
    logic [4:0]  brightness_factor;
  } cfg_t;

  // Widen 5-5-5 (red low) to RGB888 (red high) by repeating top bits
  function automatic logic [23:0] expand555(input logic [14:0] c);
    logic [4:0] r;
    logic [4:0] g;
    logic [4:0] b;
    r = c[4:0];
    g = c[9:5];
    b = c[14:10];
    return {r, r[4:2], g, g[4:2], b, b[4:2]};
  endfunction

  function automatic logic in_span(input logic [7:0] c, input logic [7:0] lo,
                                   input logic [7:0] hi);
    if (lo <= hi) begin
      return (c >= lo) && (c < hi);
    end
    return (c >= lo) || (c < hi);
  endfunction

  // Bounds: left [31:24], right [23:16], top [15:8], bottom [7:0]
  function automatic logic in_rect(input logic [31:0] bounds, input logic [7:0] x,
                                   input logic [7:0] y);
    return in_span(x, bounds[31:24], bounds[23:16]) &&
           in_span(y, bounds[15:8], bounds[7:0]);
  endfunction

  function automatic logic [4:0] clamp16(input logic [4:0] v);
    return (v > COEFF_MAX) ? COEFF_MAX : v;
  endfunction

endpackage

@@ rtl/core/pwbc_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwbc_ram: generic single-write, single-read RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module pwbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/pwbc_pixel_math.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwbc_pixel_math: window test, priority test and color effects
// Given one item and the current line entry, decides whether the item is
// stored and produces the new entry (blended or brightness adjusted).
// ----------------------------------------------------------------------------
module pwbc_pixel_math
  import pwbc_pkg::*;
(
  input  cfg_t   cfg,
  input  pix_t   pix,
  input  entry_t old_entry,
  output entry_t new_entry,
  output logic   take
);

  function automatic logic [7:0] blend_chan(input logic [7:0] s, input logic [7:0] d,
                                            input logic [4:0] eva, input logic [4:0] evb);
    logic [13:0] acc;
    logic [9:0]  q;
    acc = 14'({6'd0, s} * {9'd0, eva}) + 14'({6'd0, d} * {9'd0, evb});
    q   = acc[13:4];
    return (q > {2'd0, CHAN_MAX}) ? CHAN_MAX : q[7:0];
  endfunction

  function automatic logic [7:0] bright_chan(input logic [7:0] v, input logic [4:0] f,
                                             input logic up);
    logic [11:0] p;
    if (up) begin
      p = 12'({4'd0, CHAN_MAX - v} * {7'd0, f});
      return v + p[11:4];
    end
    p = 12'({4'd0, v} * {7'd0, f});
    return v - p[11:4];
  endfunction

  logic [7:0]  mask;
  logic [23:0] src;
  logic [23:0] fx_color;
  logic [1:0]  mode;
  logic        src_t;
  logic        dst_t;
  logic        pass;
  logic [4:0]  eva;
  logic [4:0]  evb;
  logic [4:0]  fac;

  // Pick the layer mask for this position
  always_comb begin
    if (cfg.window_enables == 3'b000) begin
      mask = MASK_ALL;
    end else if (cfg.window_enables[0] && in_rect(cfg.win0_bounds, pix.x, pix.y)) begin
      mask = cfg.inside_masks[7:0];
    end else if (cfg.window_enables[1] && in_rect(cfg.win1_bounds, pix.x, pix.y)) begin
      mask = cfg.inside_masks[15:8];
    end else if (cfg.window_enables[2] && pix.objwin) begin
      mask = cfg.outside_masks[15:8];
    end else begin
      mask = cfg.outside_masks[7:0];
    end
  end

  assign src   = expand555(pix.color);
  assign mode  = cfg.effect_control[7:6];
  assign src_t = (cfg.effect_control[5:0] & {1'b0, pix.layer}) != 6'd0;
  assign dst_t = (cfg.effect_control[13:8] & old_entry.layer) != 6'd0;
  assign pass  = ((mask[4:0] & pix.layer) != 5'd0) && ({1'b0, pix.prio} <= old_entry.prio);
  assign eva   = clamp16(cfg.blend_coeffs[4:0]);
  assign evb   = clamp16(cfg.blend_coeffs[12:8]);
  assign fac   = clamp16(cfg.brightness_factor);

  // Apply alpha blend or brightness per channel
  always_comb begin
    fx_color = src;
    if (mask[5] && (pix.semi || (mode == MODE_ALPHA && src_t && dst_t))) begin
      if (dst_t) begin
        for (int ch = 0; ch < 3; ch++) begin
          fx_color[ch*8 +: 8] = blend_chan(src[ch*8 +: 8], old_entry.color[ch*8 +: 8],
                                           eva, evb);
        end
      end
    end else if (mask[5] && src_t && (mode == MODE_BRIGHTEN || mode == MODE_DARKEN)) begin
      for (int ch = 0; ch < 3; ch++) begin
        fx_color[ch*8 +: 8] = bright_chan(src[ch*8 +: 8], fac, mode == MODE_BRIGHTEN);
      end
    end
  end

  // Build the entry to store; backdrop items always store
  always_comb begin
    if (pix.func == FUNC_BACKDROP) begin
      new_entry = '{color: src, prio: BACKDROP_PRIO, layer: BACKDROP_LAYER};
      take      = 1'b1;
    end else if (pass) begin
      new_entry = '{color: fx_color, prio: {1'b0, pix.prio}, layer: {1'b0, pix.layer}};
      take      = 1'b1;
    end else begin
      new_entry = old_entry;
      take      = 1'b0;
    end
  end

endmodule

@@ rtl/core/pixel_window_blend_compositor_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_window_blend_compositor_top: scanline layer compositor
// Keeps color, priority and layer for each pixel of one line. Backdrop items
// initialize an entry; layer pixels pass window and priority tests and are
// blended or brightness adjusted into the entry.
//
//   channel | direction | tdata (low bit up)                 | tuser
//   s_axis  | in        | pixel_x, line_number, color_in,     | func
//           |           | layer_priority, layer_bit,          |
//           |           | semi_transparent, obj_window_hit    |
//   m_axis  | out       | pixel_color                         | written
//   cfg     | in        | cfg_we / cfg_index / cfg_data, no read-back
//
// One item per cycle sustained while the output is not stalled; an accepted
// item is held in the input stage, then its result in the output register.
// The line buffer RAM has a registered read, so each item reads its entry at
// accept and writes it back as it leaves the input stage; a back-to-back hit
// on the same pixel is forwarded from the write. Reset clears one valid bit
// per entry; an entry without its bit reads as black, priority 4, backdrop
// layer. A stalled result holds the output register and the input stage; the
// block keeps taking items while the input stage has room.
// ----------------------------------------------------------------------------
module pixel_window_blend_compositor_top
  import pwbc_pkg::*;
#(
  parameter int LINE_WIDTH = LINE_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // pixel_x[7:0], line_number[15:8], color_in[30:16], layer_priority[32:31],
  // layer_bit[37:33], semi_transparent[38], obj_window_hit[39]
  input  logic [39:0] s_axis_tdata,
  // func[0]
  input  logic        s_axis_tuser,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // pixel_color[23:0]
  output logic [23:0] m_axis_tdata,
  // written[0]
  output logic        m_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int AW = $clog2(LINE_WIDTH);
  localparam int EW = $bits(entry_t);

  cfg_t            cfg;
  pix_t            in_pix;
  pix_t            s1_pix;
  logic            s1_valid;
  logic            s1_adv;
  logic            s_accept;
  logic            s1_fwd_hit;
  entry_t          s1_fwd;
  logic            s1_in_range;
  logic [AW-1:0]   in_addr;
  logic [AW-1:0]   s1_addr;
  logic [EW-1:0]   ram_rdata;
  entry_t          old_entry;
  entry_t          new_entry;
  logic            take;
  logic            ram_we;
  logic [LINE_WIDTH-1:0] entry_valid;
  logic            out_valid;
  logic [23:0]     out_color;
  logic            out_written;

  // Register file writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{window_enables: 3'd0, win0_bounds: 32'd0, win1_bounds: 32'd0,
               inside_masks: 16'd0, outside_masks: OUTSIDE_MASKS_RST,
               effect_control: 14'd0, blend_coeffs: 13'd0, brightness_factor: 5'd0};
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW_ENABLES:    cfg.window_enables    <= cfg_data[2:0];
        REG_WIN0_BOUNDS:       cfg.win0_bounds       <= cfg_data;
        REG_WIN1_BOUNDS:       cfg.win1_bounds       <= cfg_data;
        REG_INSIDE_MASKS:      cfg.inside_masks      <= cfg_data[15:0];
        REG_OUTSIDE_MASKS:     cfg.outside_masks     <= cfg_data[15:0];
        REG_EFFECT_CONTROL:    cfg.effect_control    <= cfg_data[13:0];
        REG_BLEND_COEFFS:      cfg.blend_coeffs      <= cfg_data[12:0];
        REG_BRIGHTNESS_FACTOR: cfg.brightness_factor <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Unpack the input item
  assign in_pix = '{func: s_axis_tuser, x: s_axis_tdata[7:0], y: s_axis_tdata[15:8],
                    color: s_axis_tdata[30:16], prio: s_axis_tdata[32:31],
                    layer: s_axis_tdata[37:33], semi: s_axis_tdata[38],
                    objwin: s_axis_tdata[39]};

  // Handshake between input stage and output register
  assign s1_adv        = s1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_adv;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  assign in_addr     = AW'(in_pix.x);
  assign s1_addr     = AW'(s1_pix.x);
  assign s1_in_range = 32'(s1_pix.x) < LINE_WIDTH;

  // Input stage: item plus forward of a same-pixel write at accept
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1_pix     <= in_pix;
      s1_fwd_hit <= ram_we && (s1_addr == in_addr);
      s1_fwd     <= new_entry;
    end
  end

  // Line buffer
  pwbc_ram #(
    .WIDTH(EW),
    .DEPTH(LINE_WIDTH)
  ) u_line_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(s1_addr),
    .wdata(new_entry),
    .re   (s_accept),
    .raddr(in_addr),
    .rdata(ram_rdata)
  );

  // Current entry: forwarded, stored, or reset value
  always_comb begin
    if (s1_fwd_hit) begin
      old_entry = s1_fwd;
    end else if (entry_valid[s1_addr]) begin
      old_entry = ram_rdata;
    end else begin
      old_entry = '{color: 24'd0, prio: BACKDROP_PRIO, layer: BACKDROP_LAYER};
    end
  end

  pwbc_pixel_math u_math (
    .cfg      (cfg),
    .pix      (s1_pix),
    .old_entry(old_entry),
    .new_entry(new_entry),
    .take     (take)
  );

  assign ram_we = s1_adv && s1_in_range && take;

  // Mark entries once written
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (ram_we) begin
      entry_valid[s1_addr] <= 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_color   <= s1_in_range ? new_entry.color : 24'd0;
      out_written <= s1_in_range && take;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_color;
  assign m_axis_tuser  = out_written;

  // Checks
  a_reset_clears_valid: assert property (@(posedge clk)
    rst |=> (entry_valid == '0 && !out_valid))
    else $error("entry valid bits or output not cleared by reset");

  a_write_only_on_advance: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (s1_valid && s1_adv && s1_in_range))
    else $error("line buffer written without an advancing item");

  a_forward_capture: assert property (@(posedge clk) disable iff (rst)
    (s_accept && ram_we && (s1_addr == in_addr)) |=> s1_fwd_hit)
    else $error("same-pixel write at accept not forwarded");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1_pix)))
    else $error("input stage item changed while stalled");

endmodule
